>>> rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define DELS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define DELS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dels_pkg.sv
`timescale 1ns / 1ps
package dels_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int ELEMENT_W   = 32;
  localparam int LEN_W       = 7;
  localparam int IDX_W       = 8;
  localparam int CNT_IN_W    = 7;
  localparam int IDX_EXT_W   = 10;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CNT_IN_W-1:0] POP_MAX = 7'd64;

  typedef enum logic [1:0] {
    FUNC_PUSH_TAIL,
    FUNC_PUSH_HEAD,
    FUNC_RANGE,
    FUNC_POP
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_EMPTY,
    STATUS_FULL
  } status_e;

  typedef enum logic {
    CS_IDLE,
    CS_STREAM
  } ctrl_state_e;

  // Result slot issued by the controller, aligned with the memory read data.
  typedef struct packed {
    logic             valid;
    logic             use_mem;
    status_e          status;
    logic             last;
    logic [LEN_W-1:0] len;
  } rsp_meta_t;

  typedef struct packed {
    logic [ELEMENT_W-1:0] element;
    logic [LEN_W-1:0]     len;
    status_e              status;
    logic                 last;
  } out_beat_t;

endpackage

>>> rtl/dels_mem.sv
`timescale 1ns / 1ps
module dels_mem #(
  parameter  int DEPTH = dels_pkg::DEPTH_DEF,
  parameter  int WIDTH = dels_pkg::ELEM_WIDTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dels_outq.sv
`timescale 1ns / 1ps
module dels_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dels_pkg::out_beat_t push_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dels_pkg::out_beat_t out_beat_o,
  output logic [1:0]          occ_o
);
  import dels_pkg::*;

  out_beat_t  slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] occ_q, occ_d;
  logic       pop;

  assign out_valid_o = (occ_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_beat_o  = slot_q[rd_q];
  assign occ_o       = occ_q;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    occ_d = occ_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      occ_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_beat_i;
    end
  end

endmodule

>>> rtl/dels_ctrl.sv
`timescale 1ns / 1ps
module dels_ctrl #(
  parameter  int DEPTH      = dels_pkg::DEPTH_DEF,
  parameter  int ELEM_WIDTH = dels_pkg::ELEM_WIDTH_DEF,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dels_pkg::func_e                     func_i,
  input  logic [ELEM_WIDTH-1:0]               value_i,
  input  logic signed [dels_pkg::IDX_W-1:0]   start_index_i,
  input  logic signed [dels_pkg::IDX_W-1:0]   stop_index_i,
  input  logic [dels_pkg::CNT_IN_W-1:0]       pop_count_i,
  input  logic [1:0]                          q_occ_i,
  input  logic                                q_pop_i,
  output logic                                mem_we_o,
  output logic [AW-1:0]                       mem_waddr_o,
  output logic [ELEM_WIDTH-1:0]               mem_wdata_o,
  output logic                                mem_re_o,
  output logic [AW-1:0]                       mem_raddr_o,
  output dels_pkg::rsp_meta_t                 rsp_o
);
  import dels_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [CW-1:0]    remain_q, remain_d;
  logic [LEN_W-1:0] len_q, len_d;
  rsp_meta_t        rsp_q, rsp_d;

  logic [1:0] level;
  logic       can_issue;
  logic       accept;

  logic                        full;
  logic [AW-1:0]               tail_addr;
  logic [AW-1:0]               head_dec;
  logic signed [IDX_EXT_W-1:0] len_x, s_x, e_x, s_adj, e_adj, s_cl, e_cl, n_x;
  logic                        range_empty;
  logic [CNT_IN_W-1:0]         req, cnt_x, num_x;
  logic                        pop_empty;
  logic [CW-1:0]               pop_num;

  // Ring add: base and offset sum stays below twice the depth.
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [AW:0] off);
    logic [AW+1:0] sum;
    sum = {2'b00, base} + {1'b0, off};
    if (sum >= (AW+2)'(DEPTH)) begin
      sum = sum - (AW+2)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Credit toward the output queue: queued beats plus the one in flight.
  assign level      = q_occ_i + {1'b0, rsp_q.valid};
  assign can_issue  = (level < 2'd2) || ((level == 2'd2) && q_pop_i);
  assign in_ready_o = (state_q == CS_IDLE) && can_issue;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    full      = (count_q == CW'(DEPTH));
    tail_addr = ring_add(head_q, (AW+1)'(count_q));
    head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

    len_x = $signed(IDX_EXT_W'(count_q));
    s_x   = IDX_EXT_W'(start_index_i);
    e_x   = IDX_EXT_W'(stop_index_i);
    s_adj = s_x[IDX_EXT_W-1] ? s_x + len_x : s_x;
    e_adj = e_x[IDX_EXT_W-1] ? e_x + len_x : e_x;
    s_cl  = s_adj[IDX_EXT_W-1] ? '0 : s_adj;
    e_cl  = (e_adj >= len_x) ? len_x - IDX_EXT_W'(1) : e_adj;
    range_empty = (s_cl > e_cl) || (s_cl >= len_x);
    n_x   = e_cl - s_cl + IDX_EXT_W'(1);

    req       = (pop_count_i > POP_MAX) ? POP_MAX : pop_count_i;
    cnt_x     = CNT_IN_W'(count_q);
    num_x     = (req < cnt_x) ? req : cnt_x;
    pop_empty = (req == '0) || (count_q == '0);
    pop_num   = CW'(num_x);
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    addr_d      = addr_q;
    remain_d    = remain_q;
    len_d       = len_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_addr;
    mem_wdata_o = value_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr_q;
    rsp_d       = '0;

    unique case (state_q)
      CS_IDLE: begin
        if (accept) begin
          rsp_d.valid   = 1'b1;
          rsp_d.use_mem = 1'b0;
          rsp_d.last    = 1'b1;
          rsp_d.status  = STATUS_OK;
          rsp_d.len     = LEN_W'(count_q);
          unique case (func_i)
            FUNC_PUSH_TAIL, FUNC_PUSH_HEAD: begin
              if (full) begin
                rsp_d.status = STATUS_FULL;
              end else begin
                mem_we_o = 1'b1;
                if (func_i == FUNC_PUSH_HEAD) begin
                  head_d      = head_dec;
                  mem_waddr_o = head_dec;
                end
                count_d   = count_q + CW'(1);
                rsp_d.len = LEN_W'(count_d);
              end
            end
            FUNC_RANGE: begin
              if (range_empty) begin
                rsp_d.status = STATUS_EMPTY;
              end else begin
                rsp_d.valid = 1'b0;
                addr_d      = ring_add(head_q, (AW+1)'(s_cl[AW-1:0]));
                remain_d    = CW'(n_x);
                len_d       = LEN_W'(count_q);
                state_d     = CS_STREAM;
              end
            end
            FUNC_POP: begin
              if (pop_empty) begin
                rsp_d.status = STATUS_EMPTY;
              end else begin
                rsp_d.valid = 1'b0;
                addr_d      = head_q;
                head_d      = ring_add(head_q, (AW+1)'(pop_num));
                count_d     = count_q - pop_num;
                remain_d    = pop_num;
                len_d       = LEN_W'(count_d);
                state_d     = CS_STREAM;
              end
            end
            default: ;
          endcase
        end
      end
      CS_STREAM: begin
        if (can_issue) begin
          mem_re_o      = 1'b1;
          rsp_d.valid   = 1'b1;
          rsp_d.use_mem = 1'b1;
          rsp_d.status  = STATUS_OK;
          rsp_d.last    = (remain_q == CW'(1));
          rsp_d.len     = len_q;
          addr_d        = ring_add(addr_q, (AW+1)'(1));
          remain_d      = remain_q - CW'(1);
          if (remain_q == CW'(1)) begin
            state_d = CS_IDLE;
          end
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= CS_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      remain_q <= '0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      rsp_q    <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    len_q  <= len_d;
  end

  assign rsp_o = rsp_q;

endmodule

>>> rtl/double_ended_list_store.sv
`timescale 1ns / 1ps
// Path: a push or single-result beat passes the result slot register, then the output queue;
//   a range read or pop enters the stream state first, then reads the slot memory.
// Throughput: a range read or pop holds the input off until its last element issues;
//   the single memory read port streams one element per cycle while queue credit lasts.
// Reset: clears head pointer, element count, controller and output queue at once;
//   the slot memory is not cleared and needs no clearing pass.
module double_ended_list_store #(
  parameter  int DEPTH      = dels_pkg::DEPTH_DEF,
  parameter  int ELEM_WIDTH = dels_pkg::ELEM_WIDTH_DEF,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input beats.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] value, [39:32] start_index, [47:40] stop_index, [54:48] pop_count
  input  logic [dels_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                        s_axis_tuser,
  // Result beats.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] element, [38:32] length
  output logic [dels_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);
  import dels_pkg::*;

  // Unpack the input beat.
  func_e                   func;
  logic [ELEM_WIDTH-1:0]   value_w;
  logic signed [IDX_W-1:0] start_index;
  logic signed [IDX_W-1:0] stop_index;
  logic [CNT_IN_W-1:0]     pop_count;

  assign func        = func_e'(s_axis_tuser);
  assign value_w     = ELEM_WIDTH'(s_axis_tdata[31:0]);
  assign start_index = s_axis_tdata[39:32];
  assign stop_index  = s_axis_tdata[47:40];
  assign pop_count   = s_axis_tdata[54:48];

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;
  rsp_meta_t             rsp;
  logic [1:0]            q_occ;
  logic                  q_pop;
  out_beat_t             push_beat;
  out_beat_t             out_beat;

  assign q_pop = m_axis_tvalid && m_axis_tready;

  // Controller: owns head and count, sequences memory reads for ranges and pops.
  dels_ctrl #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .func_i        (func),
    .value_i       (value_w),
    .start_index_i (start_index),
    .stop_index_i  (stop_index),
    .pop_count_i   (pop_count),
    .q_occ_i       (q_occ),
    .q_pop_i       (q_pop),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .rsp_o         (rsp)
  );

  // Slot store: one write and one registered read port.
  dels_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Merge the read data with the result slot; drop to zero where no element is read.
  always_comb begin
    push_beat.element = rsp.use_mem ? ELEMENT_W'(mem_rdata) : '0;
    push_beat.len     = rsp.len;
    push_beat.status  = rsp.status;
    push_beat.last    = rsp.last;
  end

  // Two-entry output queue parts the result side from the memory pipeline.
  dels_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rsp.valid),
    .push_beat_i (push_beat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (out_beat),
    .occ_o       (q_occ)
  );

  // Pack the result beat.
  assign m_axis_tdata = {1'b0, out_beat.len, out_beat.element};
  assign m_axis_tuser = out_beat.status;
  assign m_axis_tlast = out_beat.last;

endmodule

>>> rtl/dels_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dels_checker #(
  parameter int DEPTH = dels_pkg::DEPTH_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [dels_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                       m_axis_tuser,
  input logic                             m_axis_tlast
);
  import dels_pkg::*;

  // Hold a stalled result beat.
  `DELS_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result beat changed")

  // A refused push only happens at full depth.
  `DELS_ASSERT_IMP(a_full_len, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == STATUS_FULL), m_axis_tdata[38:32] == LEN_W'(DEPTH), "full status with length below depth")

  // Refused or empty results are single, element-free beats.
  `DELS_ASSERT_IMP(a_no_elem, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != STATUS_OK), m_axis_tlast && (m_axis_tdata[31:0] == '0), "non-ok result not a single zero beat")

  // Length never exceeds the store depth.
  `DELS_ASSERT_IMP(a_len_max, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[38:32] <= LEN_W'(DEPTH), "list length above depth")

endmodule

bind double_ended_list_store dels_checker #(.DEPTH(DEPTH)) u_dels_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> sim/double_ended_list_store_checker.sv
`timescale 1ns / 1ps
// Watches both stream channels of the list store, predicts every result beat
// from the accepted commands and compares each result beat in order.
module double_ended_list_store_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  input  logic [dels_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic [1:0]                       s_axis_tuser_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  input  logic [dels_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic [1:0]                       m_axis_tuser_i,
  input  logic                             m_axis_tlast_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               beats_seen_o
);
  import dels_pkg::*;

  localparam int SLOTS   = DEPTH_DEF;
  localparam int SLOT_AW = $clog2(DEPTH_DEF);

  logic [ELEMENT_W-1:0] slots [SLOTS];
  logic [SLOT_AW-1:0]   head_slot;
  int                   stored;
  out_beat_t            awaited_beats [$];
  int                   errors;
  int                   checked;

  function automatic void queue_beat(logic [ELEMENT_W-1:0] elem, status_e st, logic fin);
    out_beat_t b;
    b.element = elem;
    b.len     = LEN_W'(stored);
    b.status  = st;
    b.last    = fin;
    awaited_beats.push_back(b);
  endfunction

  // Apply one command to the mirrored deque and queue the beats it yields.
  function automatic void apply_list_op(func_e op, logic [ELEMENT_W-1:0] word,
                                        logic signed [IDX_W-1:0] first_idx,
                                        logic signed [IDX_W-1:0] final_idx,
                                        logic [CNT_IN_W-1:0] want);
    int lo;
    int hi;
    int n;
    logic [ELEMENT_W-1:0] taken [$];
    case (op)
      FUNC_PUSH_TAIL, FUNC_PUSH_HEAD: begin
        if (stored >= SLOTS) begin
          queue_beat('0, STATUS_FULL, 1'b1);
        end else begin
          if (op == FUNC_PUSH_TAIL) begin
            slots[head_slot + SLOT_AW'(stored)] = word;
          end else begin
            head_slot = head_slot - 1'b1;
            slots[head_slot] = word;
          end
          stored++;
          queue_beat('0, STATUS_OK, 1'b1);
        end
      end
      FUNC_RANGE: begin
        lo = int'(first_idx);
        hi = int'(final_idx);
        if (lo < 0) lo += stored;
        if (hi < 0) hi += stored;
        if (lo < 0) lo = 0;
        if (hi >= stored) hi = stored - 1;
        if (lo > hi || lo >= stored) begin
          queue_beat('0, STATUS_EMPTY, 1'b1);
        end else begin
          for (int i = lo; i <= hi; i++)
            queue_beat(slots[head_slot + SLOT_AW'(i)], STATUS_OK, i == hi);
        end
      end
      default: begin
        n = (want > POP_MAX) ? int'(POP_MAX) : int'(want);
        if (n == 0 || stored == 0) begin
          queue_beat('0, STATUS_EMPTY, 1'b1);
        end else begin
          if (n > stored) n = stored;
          // Drain first: every popped beat reports the length after the whole pop.
          for (int i = 0; i < n; i++) begin
            taken.push_back(slots[head_slot]);
            head_slot = head_slot + 1'b1;
            stored--;
          end
          for (int i = 0; i < n; i++)
            queue_beat(taken[i], STATUS_OK, i == n - 1);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_beat_t want;
    if (!rst_ni) begin
      head_slot = '0;
      stored    = 0;
      errors    = 0;
      checked   = 0;
      awaited_beats.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      beats_seen_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        apply_list_op(func_e'(s_axis_tuser_i), s_axis_tdata_i[31:0],
                      $signed(s_axis_tdata_i[39:32]), $signed(s_axis_tdata_i[47:40]),
                      s_axis_tdata_i[54:48]);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        checked++;
        if (awaited_beats.size() == 0) begin
          $error("unexpected result beat: element 0x%0h, status %0d",
                 m_axis_tdata_i[31:0], m_axis_tuser_i);
          errors++;
        end else begin
          want = awaited_beats.pop_front();
          check_field("element", want.element, m_axis_tdata_i[31:0]);
          check_field("length", want.len, m_axis_tdata_i[38:32]);
          check_field("status", want.status, m_axis_tuser_i);
          check_field("last", want.last, m_axis_tlast_i);
        end
      end
      fail_count_o <= errors;
      pending_o    <= awaited_beats.size();
      beats_seen_o <= checked;
    end
  end

endmodule

>>> sim/double_ended_list_store_tb.sv
`timescale 1ns / 1ps
// Top of the list store bench: drive commands, throttle the result side,
// and give the verdict. All prediction and comparison sits in the checker.
module double_ended_list_store_tb;
  import dels_pkg::*;

  // Stop issuing random commands once this many have been accepted.
  localparam int COMMAND_TARGET = 460;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [31:0] value, [39:32] start_index, [47:40] stop_index, [54:48] pop_count
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // [1:0] func
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [31:0] element, [38:32] length
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [1:0] status
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  int fail_count;
  int pending;
  int beats_seen;
  int commands_sent = 0;
  // Set during some segments to send back-to-back with no idle cycles.
  bit gapless = 1'b0;

  // 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  double_ended_list_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  double_ended_list_store_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .beats_seen_o    (beats_seen)
  );

  // Idle length: mostly none, often short, now and then a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one command beat, hold it until the store takes it, then idle a while.
  task automatic issue_command(func_e op, logic [31:0] word,
                               logic signed [IDX_W-1:0] first_idx,
                               logic signed [IDX_W-1:0] final_idx,
                               logic [CNT_IN_W-1:0] cnt);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, cnt, final_idx, first_idx, word};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    commands_sent++;
    gap = gapless ? 0 : idle_span();
    // Drop valid only when a real gap follows, so valid never toggles within a step.
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One random command. The segment mode biases the mix:
  // 0 grows the list, 1 drains it, 2 is unbiased noise.
  task automatic issue_random(int mode);
    int r;
    int c;
    func_e op;
    logic signed [IDX_W-1:0] a;
    logic signed [IDX_W-1:0] b;
    logic [CNT_IN_W-1:0] cnt;
    r = $urandom_range(0, 99);
    if (mode == 0) begin
      if (r < 75) op = $urandom_range(0, 1) ? FUNC_PUSH_HEAD : FUNC_PUSH_TAIL;
      else if (r < 90) op = FUNC_RANGE;
      else op = FUNC_POP;
    end else if (mode == 1) begin
      if (r < 20) op = $urandom_range(0, 1) ? FUNC_PUSH_HEAD : FUNC_PUSH_TAIL;
      else if (r < 50) op = FUNC_RANGE;
      else op = FUNC_POP;
    end else begin
      op = func_e'($urandom_range(0, 3));
    end
    // Keep most indices near the live span so ranges hit real elements.
    a = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 140) - 70);
    b = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 140) - 70);
    c = $urandom_range(0, 19);
    if (c < 12) cnt = CNT_IN_W'($urandom_range(0, 8));
    else if (c < 19) cnt = CNT_IN_W'($urandom_range(0, 64));
    else cnt = CNT_IN_W'($urandom_range(65, 127));
    issue_command(op, $urandom, a, b, cnt);
  endtask

  // Result side: stall at random, with occasional long stretches of readiness.
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_span();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12))
        @(posedge clk_i);
    end
  end

  // Command side and verdict.
  initial begin
    int mode;
    int seg_len;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_PUSH_TAIL;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store: range and pop both report empty.
    issue_command(FUNC_POP, 32'h0, 0, 0, 5);
    issue_command(FUNC_RANGE, 32'h0, 0, -1, 0);
    // Extreme element words at both ends.
    issue_command(FUNC_PUSH_TAIL, 32'h0000_0000, 0, 0, 0);
    issue_command(FUNC_PUSH_TAIL, 32'hFFFF_FFFF, 0, 0, 0);
    issue_command(FUNC_PUSH_HEAD, 32'hA5A5_A5A5, 0, 0, 0);
    issue_command(FUNC_PUSH_HEAD, 32'h5A5A_5A5A, 0, 0, 0);
    issue_command(FUNC_PUSH_TAIL, 32'h0000_0001, 0, 0, 0);
    // Ranges: whole list, clamped extremes, reversed, past the end, tail-relative.
    issue_command(FUNC_RANGE, 32'h0, 0, -1, 0);
    issue_command(FUNC_RANGE, 32'h0, -128, 127, 0);
    issue_command(FUNC_RANGE, 32'h0, 127, -128, 0);
    issue_command(FUNC_RANGE, 32'h0, 3, 1, 0);
    issue_command(FUNC_RANGE, 32'h0, 5, 10, 0);
    issue_command(FUNC_RANGE, 32'h0, -1, -1, 0);
    issue_command(FUNC_RANGE, 32'h0, 1, -2, 0);
    // Pops: zero count, single, several, saturated count, then on an empty store.
    issue_command(FUNC_POP, 32'h0, 0, 0, 0);
    issue_command(FUNC_POP, 32'h0, 0, 0, 1);
    issue_command(FUNC_POP, 32'h0, 0, 0, 2);
    issue_command(FUNC_PUSH_HEAD, 32'h8000_0000, 0, 0, 0);
    issue_command(FUNC_POP, 32'h0, 0, 0, 127);
    issue_command(FUNC_POP, 32'h0, 0, 0, 64);
    issue_command(FUNC_PUSH_TAIL, 32'h7FFF_FFFF, 0, 0, 0);
    issue_command(FUNC_POP, 32'h0, 0, 0, 64);

    // Fill past capacity so pushes at both ends get refused, then read the full
    // list and pop 40 of its elements for the longest result bursts.
    for (int i = 0; i < 70; i++)
      issue_command($urandom_range(0, 1) ? FUNC_PUSH_HEAD : FUNC_PUSH_TAIL,
                    $urandom, 0, 0, 0);
    issue_command(FUNC_PUSH_HEAD, $urandom, 0, 0, 0);
    issue_command(FUNC_PUSH_TAIL, $urandom, 0, 0, 0);
    issue_command(FUNC_RANGE, 32'h0, -128, 127, 0);
    issue_command(FUNC_RANGE, 32'h0, -64, 63, 0);
    issue_command(FUNC_POP, 32'h0, 0, 0, 40);

    // Random segments, some of them back to back; stop right at the target.
    while (commands_sent < COMMAND_TARGET) begin
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(8, 48);
      gapless = ($urandom_range(0, 4) == 0);
      repeat (seg_len) if (commands_sent < COMMAND_TARGET) issue_random(mode);
    end
    gapless = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Let the checker see the last accepted command before reading its backlog.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Run covered %0d commands: pushes at both ends incl. refused on full,",
             commands_sent);
    $display("clamped, wrapped and empty ranges, saturated pops; %0d result beats compared.",
             beats_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
